@@ src/sdget_pkg.sv @@
// ----------------------------------------------------------------------------
// sdget_pkg
// Shared types and constants of the split double-Gaussian shape evaluator.
// ----------------------------------------------------------------------------
package sdget_pkg;

  typedef logic [1:0]  region_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [35:0] recip_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_PEAK_MEAN  = 3'd0;
  localparam cfg_idx_t REG_LEFT_W1    = 3'd1;
  localparam cfg_idx_t REG_LEFT_W2    = 3'd2;
  localparam cfg_idx_t REG_RIGHT_W1   = 3'd3;
  localparam cfg_idx_t REG_RIGHT_W2   = 3'd4;
  localparam cfg_idx_t REG_TAIL_START = 3'd5;
  localparam cfg_idx_t REG_TAIL_DECAY = 3'd6;
  localparam cfg_idx_t REG_MIX_FRAC   = 3'd7;

  // Region codes.
  localparam region_t REGION_LEFT  = 2'd0;
  localparam region_t REGION_RIGHT = 2'd1;
  localparam region_t REGION_TAIL  = 2'd2;

  localparam logic [15:0] ONE_Q15   = 16'd32768;
  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [31:0] MIX_RESET = 32'd1073758208;

  // Ratio unit: Q7.16 quotient with up to 22 quotient bits.
  localparam int RATIO_QB        = 22;
  localparam int RATIO_W         = RATIO_QB + 1;
  localparam int RATIO_FRAC      = 16;
  localparam int GAUSS_LIM_SHIFT = 4;
  localparam int TAIL_LIM_SHIFT  = 6;
  localparam int DIV_LAT         = RATIO_QB + 1;

  // Exponential unit.
  localparam int          EXP_TW          = 24;
  localparam int          EXP_KW          = 9;
  localparam logic [15:0] LN2_Q16         = 16'd45426;
  localparam int          LN2_RECIP_SHIFT = 40;
  localparam logic [24:0] LN2_RECIP       = 25'((64'd1 << 40) / 64'd45426);
  localparam int          EXP_STEPS       = 11;
  localparam int          SERIES_SHIFT    = 36;
  localparam int          EXP_LAT         = 2 + 2 * EXP_STEPS + 1;

  // Rounded-up reciprocals 2^36/n, exact floor division for 32-bit values.
  localparam recip_t SERIES_RECIP [2:12] = '{
    36'(((64'd1 << 36) + 64'd1)  / 64'd2),
    36'(((64'd1 << 36) + 64'd2)  / 64'd3),
    36'(((64'd1 << 36) + 64'd3)  / 64'd4),
    36'(((64'd1 << 36) + 64'd4)  / 64'd5),
    36'(((64'd1 << 36) + 64'd5)  / 64'd6),
    36'(((64'd1 << 36) + 64'd6)  / 64'd7),
    36'(((64'd1 << 36) + 64'd7)  / 64'd8),
    36'(((64'd1 << 36) + 64'd8)  / 64'd9),
    36'(((64'd1 << 36) + 64'd9)  / 64'd10),
    36'(((64'd1 << 36) + 64'd10) / 64'd11),
    36'(((64'd1 << 36) + 64'd11) / 64'd12)
  };

endpackage

@@ src/sdget_div.sv @@
// ----------------------------------------------------------------------------
// sdget_div
// Pipelined restoring divider giving a saturated Q7.16 ratio, one bit a stage.
// ----------------------------------------------------------------------------
module sdget_div #(
  parameter int DEN_W     = 32,
  parameter int LIM_SHIFT = 4
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [DEN_W:0]                num_i,
  input  logic [DEN_W-1:0]              den_i,
  output logic [sdget_pkg::RATIO_W-1:0] ratio_o
);
  import sdget_pkg::*;

  localparam int NUM_W = DEN_W + 1;
  localparam int LOW_W = RATIO_QB - RATIO_FRAC;
  localparam int CMP_W = NUM_W + LIM_SHIFT;

  logic [DEN_W-1:0]    rem_r [RATIO_QB];
  logic [DEN_W-1:0]    den_r [RATIO_QB];
  logic [LOW_W-1:0]    low_r [RATIO_QB];
  logic [RATIO_QB-1:0] q_r   [RATIO_QB+1];
  logic                sat_r [RATIO_QB+1];

  logic [DEN_W-1:0]    rem_nxt [RATIO_QB];
  logic                take    [RATIO_QB];
  logic [DEN_W-1:0]    den0;
  logic                sat0;

  always_comb begin
    den0 = (den_i == '0) ? DEN_W'(1) : den_i;
    sat0 = CMP_W'(num_i) >= (CMP_W'(den0) << LIM_SHIFT);
  end

  always_comb begin
    logic [DEN_W:0] shifted;
    for (int s = 0; s < RATIO_QB; s++) begin
      shifted    = {rem_r[s], low_r[s][LOW_W-1]};
      take[s]    = shifted >= {1'b0, den_r[s]};
      rem_nxt[s] = take[s] ? DEN_W'(shifted - {1'b0, den_r[s]}) : shifted[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DEN_W'(num_i >> LOW_W);
      den_r[0] <= den0;
      low_r[0] <= num_i[LOW_W-1:0];
      q_r[0]   <= '0;
      sat_r[0] <= sat0;
      for (int s = 1; s <= RATIO_QB; s++) begin
        q_r[s]   <= {q_r[s-1][RATIO_QB-2:0], take[s-1]};
        sat_r[s] <= sat_r[s-1];
        if (s < RATIO_QB) begin
          rem_r[s] <= rem_nxt[s-1];
          den_r[s] <= den_r[s-1];
          low_r[s] <= low_r[s-1] << 1;
        end
      end
    end
  end

  assign ratio_o = sat_r[RATIO_QB] ? (RATIO_W'(1) << (RATIO_FRAC + LIM_SHIFT))
                                   : {1'b0, q_r[RATIO_QB]};

endmodule

@@ src/sdget_exp.sv @@
// ----------------------------------------------------------------------------
// sdget_exp
// Pipelined exp(-t): range reduction by ln2, then a Taylor series one term
// per two stages, then the power-of-two shift into Q1.31.
// ----------------------------------------------------------------------------
module sdget_exp (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sdget_pkg::EXP_TW-1:0] t_i,
  output logic [31:0]                  e_o
);
  import sdget_pkg::*;

  localparam int PW = EXP_TW + 25;

  logic [EXP_TW-1:0]  t0_r;
  logic [EXP_KW-1:0]  kest_r;
  logic [PW-1:0]      prod0;

  logic [24:0]        r0;
  logic               fix;
  logic [31:0]        rq1;
  logic [EXP_KW-1:0]  k1;

  // Series state after the reduction stage and after each divide stage.
  logic [31:0]        term_r [EXP_STEPS+1];
  logic signed [34:0] sum_r  [EXP_STEPS+1];
  logic [31:0]        rq_r   [EXP_STEPS+1];
  logic [EXP_KW-1:0]  k_r    [EXP_STEPS+1];

  // Multiply stages.
  logic [31:0]        pm_r   [EXP_STEPS];
  logic signed [34:0] msum_r [EXP_STEPS];
  logic [31:0]        mrq_r  [EXP_STEPS];
  logic [EXP_KW-1:0]  mk_r   [EXP_STEPS];

  logic [31:0]        pm_nxt   [EXP_STEPS];
  logic [31:0]        dterm    [EXP_STEPS];
  logic signed [34:0] dsum_nxt [EXP_STEPS];

  logic [32:0]        sum_u;
  logic [6:0]         sh;
  logic [31:0]        e_r;

  assign prod0 = PW'(t_i) * PW'(LN2_RECIP);

  always_comb begin
    r0  = 25'(t0_r) - 25'(kest_r) * 25'(LN2_Q16);
    fix = r0 >= 25'(LN2_Q16);
    k1  = fix ? kest_r + EXP_KW'(1) : kest_r;
    rq1 = fix ? {16'(r0 - 25'(LN2_Q16)), 16'h0000} : {r0[15:0], 16'h0000};
  end

  always_comb begin
    for (int j = 0; j < EXP_STEPS; j++) begin
      pm_nxt[j] = 32'((64'(term_r[j]) * 64'(rq_r[j])) >> 32);
      dterm[j]  = 32'((68'(pm_r[j]) * 68'(SERIES_RECIP[j+2])) >> SERIES_SHIFT);
      // Odd powers of r enter with a minus sign.
      if (((j + 2) % 2) == 1) begin
        dsum_nxt[j] = msum_r[j] - $signed({3'b000, dterm[j]});
      end else begin
        dsum_nxt[j] = msum_r[j] + $signed({3'b000, dterm[j]});
      end
    end
  end

  always_comb begin
    sum_u = sum_r[EXP_STEPS][32:0];
    sh    = 7'(k_r[EXP_STEPS][5:0]) + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r      <= t_i;
      kest_r    <= EXP_KW'(prod0 >> LN2_RECIP_SHIFT);
      term_r[0] <= rq1;
      sum_r[0]  <= 35'sh1_0000_0000 - $signed({3'b000, rq1});
      rq_r[0]   <= rq1;
      k_r[0]    <= k1;
      for (int j = 0; j < EXP_STEPS; j++) begin
        pm_r[j]     <= pm_nxt[j];
        msum_r[j]   <= sum_r[j];
        mrq_r[j]    <= rq_r[j];
        mk_r[j]     <= k_r[j];
        term_r[j+1] <= dterm[j];
        sum_r[j+1]  <= dsum_nxt[j];
        rq_r[j+1]   <= mrq_r[j];
        k_r[j+1]    <= mk_r[j];
      end
      // A shift of 64 or more underflows to zero.
      e_r <= (k_r[EXP_STEPS] >= EXP_KW'(63)) ? 32'd0 : 32'(sum_u >> sh);
    end
  end

  assign e_o = e_r;

endmodule

@@ src/split_double_gauss_exp_tail_eval.sv @@
// ----------------------------------------------------------------------------
// split_double_gauss_exp_tail_eval
// Peak shape evaluator: split double Gaussian with an exponential tail.
// ----------------------------------------------------------------------------
// The block takes one sample word on the in_ channel and returns one result
// word on the out_ channel: the shape value in unsigned Q1.31 and a region
// code (left of the mean, right of the mean, or exponential tail).
// The shape parameters live in eight registers written through the cfg_
// port; the user must see that they are written only while no word is in
// flight, as the block itself does not enforce it. Throughput is one word
// per clock while in_stall is low. The pipeline depth is set by the 22-bit
// bit-per-stage ratio dividers (23 stages) and the exponential series, which
// spends two stages on each of its terms.
// The whole datapath moves on one enable. Behind it sit an output register
// and a one-word skid register: when the receiver stalls, the word leaving
// the pipeline is parked in the skid register and in_stall rises on the next
// cycle, so no stall path runs combinationally from out_ to in_.
// A synchronous active-low reset empties the pipeline and the output stage
// and restores the register reset values (unit widths and decay, mean zero,
// tail start at the largest positive value, both fractions one half).
// ----------------------------------------------------------------------------
module split_double_gauss_exp_tail_eval #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [DATA_WIDTH-1:0]                      in_sample_x,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [31:0]                                out_shape_value,
  output sdget_pkg::region_t                         out_region,
  input  logic                                       cfg_we,
  input  sdget_pkg::cfg_idx_t                        cfg_index,
  input  logic [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] cfg_wdata
);
  import sdget_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int P_DIV = DIV_LAT;
  localparam int P_SQ  = P_DIV + 1;
  localparam int P_EXP = P_SQ + EXP_LAT;
  localparam int P_MIX = P_EXP + 1;
  localparam int P_TL  = P_MIX + 1;
  localparam int P_FIN = P_TL + 1;
  localparam int DEPTH = P_FIN + 1;

  // Configuration registers.
  logic signed [DW-1:0] peak_mean_r;
  logic [DW-1:0]        left_w1_r, left_w2_r, right_w1_r, right_w2_r;
  logic signed [DW-1:0] tail_start_r;
  logic [DW-1:0]        tail_decay_r;
  logic [31:0]          mix_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_mean_r  <= '0;
      left_w1_r    <= DW'(32'd65536);
      left_w2_r    <= DW'(32'd65536);
      right_w1_r   <= DW'(32'd65536);
      right_w2_r   <= DW'(32'd65536);
      tail_start_r <= {1'b0, {(DW-1){1'b1}}};
      tail_decay_r <= DW'(32'd65536);
      mix_frac_r   <= MIX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PEAK_MEAN:  peak_mean_r  <= cfg_wdata[DW-1:0];
        REG_LEFT_W1:    left_w1_r    <= cfg_wdata[DW-1:0];
        REG_LEFT_W2:    left_w2_r    <= cfg_wdata[DW-1:0];
        REG_RIGHT_W1:   right_w1_r   <= cfg_wdata[DW-1:0];
        REG_RIGHT_W2:   right_w2_r   <= cfg_wdata[DW-1:0];
        REG_TAIL_START: tail_start_r <= cfg_wdata[DW-1:0];
        REG_TAIL_DECAY: tail_decay_r <= cfg_wdata[DW-1:0];
        REG_MIX_FRAC:   mix_frac_r   <= cfg_wdata[31:0];
      endcase
    end
  end

  // Pipeline enable: the datapath advances whenever the skid register is free.
  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Front stage: differences, region decision and operand selection. In the
  // tail region the Gaussian pair is evaluated at the tail start, which gives
  // the scale of the tail.
  logic signed [DW-1:0] x;
  logic signed [DW:0]   dxm, dts, dxt;
  logic                 is_tail, is_right;
  logic [DW:0]          gnum;
  region_t              region;

  always_comb begin
    x        = in_sample_x;
    dxm      = (DW+1)'(x) - (DW+1)'(peak_mean_r);
    dts      = (DW+1)'(tail_start_r) - (DW+1)'(peak_mean_r);
    dxt      = (DW+1)'(x) - (DW+1)'(tail_start_r);
    is_tail  = x > tail_start_r;
    is_right = x > peak_mean_r;
    if (is_tail) begin
      gnum = dts[DW] ? (DW+1)'(-dts) : dts;
    end else begin
      gnum = dxm[DW] ? (DW+1)'(-dxm) : dxm;
    end
    if (is_tail) begin
      region = REGION_TAIL;
    end else if (is_right) begin
      region = REGION_RIGHT;
    end else begin
      region = REGION_LEFT;
    end
  end

  logic [DW:0]   gnum_r, tnum_r;
  logic [DW-1:0] gden1_r, gden2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gnum_r  <= gnum;
      gden1_r <= (region == REGION_LEFT) ? left_w1_r : right_w1_r;
      gden2_r <= (region == REGION_LEFT) ? left_w2_r : right_w2_r;
      tnum_r  <= is_tail ? dxt : '0;
    end
  end

  // Valid bits and region codes travel alongside the datapath.
  logic    v_r  [DEPTH];
  region_t rg_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rg_r[0] <= region;
      for (int i = 1; i < DEPTH; i++) begin
        rg_r[i] <= rg_r[i-1];
      end
    end
  end

  // Ratio dividers.
  logic [RATIO_W-1:0] a1, a2, at;

  sdget_div #(.DEN_W(DW), .LIM_SHIFT(GAUSS_LIM_SHIFT)) u_div_g1 (
    .clk(clk), .en(en), .num_i(gnum_r), .den_i(gden1_r), .ratio_o(a1)
  );
  sdget_div #(.DEN_W(DW), .LIM_SHIFT(GAUSS_LIM_SHIFT)) u_div_g2 (
    .clk(clk), .en(en), .num_i(gnum_r), .den_i(gden2_r), .ratio_o(a2)
  );
  sdget_div #(.DEN_W(DW), .LIM_SHIFT(TAIL_LIM_SHIFT)) u_div_t (
    .clk(clk), .en(en), .num_i(tnum_r), .den_i(tail_decay_r), .ratio_o(at)
  );

  // Gaussian arguments: a*a/2 in Q8.16. A Gaussian ratio is at most 16.0,
  // so 21 bits of it carry the whole value.
  logic [41:0]       sq1, sq2;
  logic [EXP_TW-1:0] tg1_r, tg2_r, tt_r;

  assign sq1 = 42'(a1[20:0]) * 42'(a1[20:0]);
  assign sq2 = 42'(a2[20:0]) * 42'(a2[20:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      tg1_r <= EXP_TW'(sq1 >> 17);
      tg2_r <= EXP_TW'(sq2 >> 17);
      tt_r  <= EXP_TW'(at);
    end
  end

  logic [31:0] e1, e2, et;

  sdget_exp u_exp_g1 (.clk(clk), .en(en), .t_i(tg1_r), .e_o(e1));
  sdget_exp u_exp_g2 (.clk(clk), .en(en), .t_i(tg2_r), .e_o(e2));
  sdget_exp u_exp_t  (.clk(clk), .en(en), .t_i(tt_r),  .e_o(et));

  // Mixing stage. Fractions above one are clamped to one.
  logic [15:0] fl, fr, f;
  logic [48:0] mix_sum;
  logic [31:0] mix_r, etail_r;

  always_comb begin
    fl      = (mix_frac_r[15:0] > ONE_Q15) ? ONE_Q15 : mix_frac_r[15:0];
    fr      = (mix_frac_r[31:16] > ONE_Q15) ? ONE_Q15 : mix_frac_r[31:16];
    f       = (rg_r[P_EXP] == REGION_LEFT) ? fl : fr;
    mix_sum = 49'(f) * 49'(e1) + 49'(ONE_Q15 - f) * 49'(e2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mix_r   <= 32'(mix_sum >> 15);
      etail_r <= et;
    end
  end

  // Tail scaling stage.
  logic [63:0] tprod;
  logic [31:0] tprod_r, mixd_r;

  assign tprod = 64'(mix_r) * 64'(etail_r);

  always_ff @(posedge clk) begin
    if (en) begin
      tprod_r <= 32'(tprod >> 31);
      mixd_r  <= mix_r;
    end
  end

  // Final selection and saturation at 1.0.
  logic [31:0] sel, val_r;

  assign sel = (rg_r[P_TL] == REGION_TAIL) ? tprod_r : mixd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= (sel > ONE_Q31) ? ONE_Q31 : sel;
    end
  end

  // Output register and skid register.
  logic        out_v_r;
  logic [31:0] out_val_r, skid_val_r;
  region_t     out_rg_r, skid_rg_r;
  logic        out_free;

  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= v_r[P_FIN];
      end
    end else if (!skid_v_r && v_r[P_FIN]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_val_r <= skid_v_r ? skid_val_r : val_r;
      out_rg_r  <= skid_v_r ? skid_rg_r : rg_r[P_FIN];
    end else if (!skid_v_r) begin
      skid_val_r <= val_r;
      skid_rg_r  <= rg_r[P_FIN];
    end
  end

  assign out_valid       = out_v_r;
  assign out_shape_value = out_val_r;
  assign out_region      = out_rg_r;

endmodule

@@ src/sdget_checker.sv @@
// ----------------------------------------------------------------------------
// sdget_checker
// Port-level checks of the shape evaluator, bound to its top level.
// ----------------------------------------------------------------------------
module sdget_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [31:0]        out_shape_value,
  input sdget_pkg::region_t out_region
);
  import sdget_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or skid stage not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shape_value) && $stable(out_region))
    else $error("stalled result word changed");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("skid word not drained when the receiver took a word");

  a_skid_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while no result word is waiting");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_shape_value <= ONE_Q31 &&
      (out_region == REGION_LEFT || out_region == REGION_RIGHT ||
       out_region == REGION_TAIL))
    else $error("result word out of range");

endmodule

bind split_double_gauss_exp_tail_eval sdget_checker u_sdget_checker (.*);
